// ===== design/krt_pkg.sv =====
// Shared types and constants for the keyed record table.
// No dependencies; used by krt_cell and keyed_record_table.
package krt_pkg;

	// Default table size and the index width that goes with it
	localparam int CAPACITY_DEF = 32;
	localparam int IDX_W_DEF    = 5;

	// Command codes
	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_DEL  = 2'd1,
		CMD_READ = 2'd2,
		CMD_LIST = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_DUP     = 3'd2,
		ST_MISSING = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// One stored record
	typedef struct packed {
		logic [31:0] key;
		logic [7:0]  year;
		logic [15:0] course_a;
		logic [7:0]  grade_a;
		logic [15:0] course_b;
		logic [7:0]  grade_b;
		logic [15:0] course_c;
		logic [7:0]  grade_c;
	} rec_t;

	// Broadcast control to the row of cells
	typedef struct packed {
		logic rotate;   // every cell takes its upper neighbor (ring)
		logic compact;  // cells at or above pos take their upper neighbor
		logic load;     // the cell at pos takes the new record
	} cell_ctl_t;

endpackage

// ===== design/krt_cell.sv =====
// One slot of the record ring: holds a record and hands it to its lower neighbor.
// Depends on krt_pkg (rec_t, cell_ctl_t).
module krt_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = krt_pkg::IDX_W_DEF
) (
	input  logic               clk,
	input  krt_pkg::cell_ctl_t ctl,
	input  logic [IDX_W-1:0]   pos,
	input  krt_pkg::rec_t      nbr,
	input  krt_pkg::rec_t      new_rec,
	output krt_pkg::rec_t      rec
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	krt_pkg::rec_t rec_q;

	// Shift from the neighbor on rotate or compaction, else load on a matching write
	always_ff @(posedge clk) begin
		if (ctl.rotate || (ctl.compact && (MY_IDX >= pos))) begin
			rec_q <= nbr;
		end else if (ctl.load && (MY_IDX == pos)) begin
			rec_q <= new_rec;
		end
	end

	assign rec = rec_q;

endmodule

// ===== design/keyed_record_table.sv =====
// Keyed record table: controller, result register and the ring of record cells.
// Depends on krt_pkg and krt_cell.
//
// Records sit in a ring of CAPACITY cells. A command is taken when start is high
// and busy is low. The ring then rotates once around so each record passes the
// comparator at cell 0, followed by a finishing state that appends, compacts or
// reports; busy stays high until that state ends. Add, delete and read give one
// result, after the finishing state. List gives one result per stored key while
// the ring turns, one per cycle, or a single empty result at the end. Each result
// is shown for one cycle with strobe high and cannot be held off by the receiver.
module keyed_record_table #(
	parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] key,
	input  logic [7:0]  year,
	input  logic [15:0] course_a,
	input  logic [7:0]  grade_a,
	input  logic [15:0] course_b,
	input  logic [7:0]  grade_b,
	input  logic [15:0] course_c,
	input  logic [7:0]  grade_c,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [31:0] out_key,
	output logic [7:0]  out_year,
	output logic [15:0] out_course_a,
	output logic [7:0]  out_grade_a,
	output logic [15:0] out_course_b,
	output logic [7:0]  out_grade_b,
	output logic [15:0] out_course_c,
	output logic [7:0]  out_grade_c,
	output logic [5:0]  used_count,
	output logic        is_full,
	output logic        last
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	krt_pkg::state_t    state_q, state_d;
	krt_pkg::cmd_t      cmd_q;
	krt_pkg::rec_t      new_rec_q;
	krt_pkg::rec_t      hit_rec_q;
	logic [IDX_W-1:0]   hit_pos_q;
	logic               hit_q;
	logic [IDX_W-1:0]   step_q;
	logic [CNT_W-1:0]   count_q, count_d;

	krt_pkg::cell_ctl_t ctl;
	logic [IDX_W-1:0]   cell_pos;
	krt_pkg::rec_t      cell_rec [CAPACITY];
	krt_pkg::rec_t      head;

	logic               accept;
	logic               in_range;
	logic               scan_end;
	logic               scan_hit;
	logic               res_emit;
	krt_pkg::status_t   res_status;
	krt_pkg::rec_t      res_rec;
	logic               res_last;

	// Result register
	logic               strobe_q;
	krt_pkg::status_t   status_q;
	krt_pkg::rec_t      out_rec_q;
	logic [CNT_W-1:0]   used_q;
	logic               full_q;
	logic               last_q;

	// Ring of cells: each takes the record of the next one up, the top wraps to cell 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		krt_cell #(
			.INDEX (i),
			.IDX_W (IDX_W)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.pos     (cell_pos),
			.nbr     (cell_rec[(i + 1) % CAPACITY]),
			.new_rec (new_rec_q),
			.rec     (cell_rec[i])
		);
	end

	assign head     = cell_rec[0];
	assign accept   = start && (state_q == krt_pkg::S_IDLE);
	assign busy     = (state_q != krt_pkg::S_IDLE);
	assign in_range = (CNT_W'(step_q) < count_q);
	assign scan_end = (step_q == LAST_IDX);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, cell control and result selection
	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		cell_pos   = hit_pos_q;
		scan_hit   = 1'b0;
		res_emit   = 1'b0;
		res_status = krt_pkg::ST_OK;
		res_rec    = '0;
		res_last   = 1'b1;
		count_d    = count_q;
		case (state_q)
			krt_pkg::S_IDLE: begin
				if (start) begin
					state_d = krt_pkg::S_SCAN;
				end
			end
			krt_pkg::S_SCAN: begin
				// head holds logical record step_q during the rotation
				ctl.rotate = 1'b1;
				scan_hit   = in_range && (head.key == new_rec_q.key) && !hit_q;
				if ((cmd_q == krt_pkg::CMD_LIST) && in_range) begin
					res_emit    = 1'b1;
					res_rec.key = head.key;
					res_last    = ((CNT_W'(step_q) + CNT_W'(1)) == count_q);
				end
				if (scan_end) begin
					state_d = krt_pkg::S_FINISH;
				end
			end
			krt_pkg::S_FINISH: begin
				state_d = krt_pkg::S_IDLE;
				case (cmd_q)
					krt_pkg::CMD_ADD: begin
						res_emit = 1'b1;
						if (count_q >= CAP_CNT) begin
							res_status = krt_pkg::ST_FULL;
						end else if (hit_q) begin
							res_status = krt_pkg::ST_DUP;
						end else begin
							ctl.load = 1'b1;
							cell_pos = IDX_W'(count_q);
							count_d  = count_q + CNT_W'(1);
						end
					end
					krt_pkg::CMD_DEL: begin
						res_emit = 1'b1;
						if (hit_q) begin
							ctl.compact = 1'b1;
							count_d     = count_q - CNT_W'(1);
						end else begin
							res_status = krt_pkg::ST_MISSING;
						end
					end
					krt_pkg::CMD_READ: begin
						res_emit = 1'b1;
						if (hit_q) begin
							res_rec = hit_rec_q;
						end else begin
							res_status = krt_pkg::ST_MISSING;
						end
					end
					krt_pkg::CMD_LIST: begin
						// non-empty lists were sent during the scan
						if (count_q == '0) begin
							res_emit   = 1'b1;
							res_status = krt_pkg::ST_EMPTY;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
				state_d = krt_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers: record count, match flag, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			hit_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			count_q  <= count_d;
			strobe_q <= res_emit;
			if (accept) begin
				hit_q <= 1'b0;
			end else if (scan_hit) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Command capture, scan step and match capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q              <= krt_pkg::cmd_t'(command);
			new_rec_q.key      <= key;
			new_rec_q.year     <= year;
			new_rec_q.course_a <= course_a;
			new_rec_q.grade_a  <= grade_a;
			new_rec_q.course_b <= course_b;
			new_rec_q.grade_b  <= grade_b;
			new_rec_q.course_c <= course_c;
			new_rec_q.grade_c  <= grade_c;
			step_q             <= '0;
		end else if (state_q == krt_pkg::S_SCAN) begin
			step_q <= step_q + IDX_W'(1);
		end
		if (scan_hit) begin
			hit_rec_q <= head;
			hit_pos_q <= step_q;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (res_emit) begin
			status_q  <= res_status;
			out_rec_q <= res_rec;
			used_q    <= count_d;
			full_q    <= (count_d >= CAP_CNT);
			last_q    <= res_last;
		end
	end

	assign strobe       = strobe_q;
	assign status       = status_q;
	assign out_key      = out_rec_q.key;
	assign out_year     = out_rec_q.year;
	assign out_course_a = out_rec_q.course_a;
	assign out_grade_a  = out_rec_q.grade_a;
	assign out_course_b = out_rec_q.course_b;
	assign out_grade_b  = out_rec_q.grade_b;
	assign out_course_c = out_rec_q.course_c;
	assign out_grade_c  = out_rec_q.grade_c;
	assign used_count   = 6'(used_q);
	assign is_full      = full_q;
	assign last         = last_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("record count above capacity");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q != krt_pkg::S_IDLE))
		else $error("result beat without a command in progress");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == krt_pkg::S_SCAN) && (step_q == '0) && !hit_q)
		else $error("accepted command did not start a scan");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == krt_pkg::S_FINISH))
		else $error("record count changed outside the finishing cycle");

endmodule
